// ===== rtl/core/egw_pkg.sv =====
// Shared types and constants of the Exp-Golomb bit writer.
`default_nettype none

package egw_pkg;

    typedef logic [2:0]  egw_kind_t;
    typedef logic [5:0]  egw_count_t;
    typedef logic [7:0]  egw_byte_t;
    typedef logic [15:0] egw_total_t;

    localparam egw_kind_t KIND_FIXED   = 3'd0;
    localparam egw_kind_t KIND_UE      = 3'd1;
    localparam egw_kind_t KIND_SE      = 3'd2;
    localparam egw_kind_t KIND_TRAIL   = 3'd3;
    localparam egw_kind_t KIND_RESTART = 3'd4;

    localparam int CMD_VALUE_W  = 32;
    localparam int TOTAL_W      = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam egw_total_t TOTAL_MAX = 16'hFFFF;

    // Operation that the front hands to the packer.
    typedef enum logic [1:0] {
        OP_DATA,
        OP_TRAIL,
        OP_RESTART
    } egw_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/egw_cmd_if.sv =====
// Command channel: one item is one writer command.
`default_nettype none

interface egw_cmd_if;
    import egw_pkg::*;

    logic       valid;
    logic       ready;
    egw_kind_t  kind;
    logic [CMD_VALUE_W-1:0] value;
    egw_count_t bit_count;

    modport source (output valid, output kind, output value, output bit_count, input ready);
    modport sink   (input valid, input kind, input value, input bit_count, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/egw_byte_if.sv =====
// Byte channel: one item is one finished stream byte.
`default_nettype none

interface egw_byte_if;
    import egw_pkg::*;

    logic       valid;
    logic       ready;
    egw_byte_t  out_byte;
    logic       last;
    egw_total_t total_bits;

    modport source (output valid, output out_byte, output last, output total_bits, input ready);
    modport sink   (input valid, input out_byte, input last, input total_bits, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/exp_golomb_bit_writer_unit.sv =====
// Exp-Golomb bit writer: H.264 header bit packer built from front end, queue and packer.
//
// Channel cmd takes one command per item: kind selects fixed bits, ue(v), se(v),
// trailing bits or a stream restart; value is the operand and bit_count the
// number of low bits for fixed writes. Channel res gives one finished stream
// byte per item, first bit in bit 7; last marks the final byte of a command
// and total_bits holds the saturating bit count after that whole command.
// A command that completes no byte gives no item; unknown kinds are dropped.
// The front end needs two register stages to form the code word and its
// length, then the command waits in a two-entry queue. The first byte passes
// through stage one, stage two, the queue, the packer window and the output
// register. The packer loads one command, then completes its bytes one by
// one and takes no new command until it has passed on the last. The front end
// keeps accepting while the packer drains bytes, until the queue is full.
// A stalled receiver holds the byte in the output register; the packer and
// then the front end stop behind it without losing state. Reset clears the
// pending bits, the bit count and all valid flags.
`default_nettype none

module exp_golomb_bit_writer_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    egw_cmd_if.sink    cmd,
    egw_byte_if.source res
);
    import egw_pkg::*;

    localparam int SW = 2 * VALUE_BITS;
    localparam int LW = $clog2(SW);

    logic          f_valid;
    logic          f_ready;
    egw_op_t       f_op;
    logic [SW-1:0] f_s;
    logic [LW-1:0] f_len;
    logic          b_valid;
    logic          b_ready;
    egw_op_t       b_op;
    logic [SW-1:0] b_s;
    logic [LW-1:0] b_len;

    egw_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_op    (f_op),
        .q_s     (f_s),
        .q_len   (f_len)
    );

    egw_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .in_s      (f_s),
        .in_len    (f_len),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_op    (b_op),
        .out_s     (b_s),
        .out_len   (b_len)
    );

    egw_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_op    (b_op),
        .q_s     (b_s),
        .q_len   (b_len),
        .res     (res)
    );

endmodule

`default_nettype wire

// ===== rtl/core/egw_front.sv =====
// Command front end: forms the code word and its length, left-aligns it.
`default_nettype none

module egw_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    egw_cmd_if.sink                              cmd,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output egw_pkg::egw_op_t                     q_op,
    output logic [2*VALUE_BITS-1:0]              q_s,
    output logic [$clog2(2*VALUE_BITS)-1:0]      q_len
);
    import egw_pkg::*;

    localparam int SW  = 2 * VALUE_BITS;
    localparam int LW  = $clog2(SW);
    localparam int SHW = LW + 1;

    logic [VALUE_BITS-1:0] u;
    logic [5:0]            cnt_clip;
    logic [VALUE_BITS-1:0] fix_code;
    logic [VALUE_BITS-1:0] ue_code;
    logic [VALUE_BITS-1:0] se_dbl;
    logic [VALUE_BITS-1:0] se_code;
    logic                  keep;
    egw_op_t               op_c;
    logic [VALUE_BITS-1:0] code_c;
    logic                  fix_c;
    logic [LW-1:0]         fl_c;

    logic                  v1_reg, v1_next;
    egw_op_t               op1_reg, op1_next;
    logic [VALUE_BITS-1:0] code1_reg, code1_next;
    logic                  fix1_reg, fix1_next;
    logic [LW-1:0]         fl1_reg, fl1_next;

    logic                  v2_reg, v2_next;
    egw_op_t               op2_reg, op2_next;
    logic [VALUE_BITS-1:0] code2_reg, code2_next;
    logic [LW-1:0]         len2_reg, len2_next;

    logic                  adv1;
    logic                  adv2;
    logic [LW-1:0]         blen;
    logic [LW-1:0]         len_c;

    assign adv2      = !v2_reg || q_ready;
    assign adv1      = !v1_reg || adv2;
    assign cmd.ready = adv1;

    // Stage one: value of the code word (code number plus one, or the masked fixed bits).
    always_comb
    begin
        u        = cmd.value[VALUE_BITS-1:0];
        cnt_clip = (cmd.bit_count > 6'(VALUE_BITS)) ? 6'(VALUE_BITS) : cmd.bit_count;
        fix_code = u & ~({VALUE_BITS{1'b1}} << cnt_clip);
        ue_code  = u + VALUE_BITS'(1);
        se_dbl   = u << 1;
        // Negative values and zero map to 1 - 2v, positive ones to 2v.
        se_code  = (u[VALUE_BITS-1] || (u == '0)) ? (VALUE_BITS'(1) - se_dbl) : se_dbl;
        keep     = 1'b1;
        op_c     = OP_DATA;
        code_c   = '0;
        fix_c    = 1'b0;
        fl_c     = '0;
        case (cmd.kind)
            KIND_FIXED:
            begin
                code_c = fix_code;
                fix_c  = 1'b1;
                fl_c   = LW'(cnt_clip);
            end
            KIND_UE:      code_c = ue_code;
            KIND_SE:      code_c = se_code;
            KIND_TRAIL:   op_c   = OP_TRAIL;
            KIND_RESTART: op_c   = OP_RESTART;
            default:      keep   = 1'b0;
        endcase
    end

    always_comb
    begin
        v1_next    = v1_reg;
        op1_next   = op1_reg;
        code1_next = code1_reg;
        fix1_next  = fix1_reg;
        fl1_next   = fl1_reg;
        if (adv1)
        begin
            v1_next    = cmd.valid && keep;
            op1_next   = op_c;
            code1_next = code_c;
            fix1_next  = fix_c;
            fl1_next   = fl_c;
        end
    end

    // Stage two: bit length of the code, then the written length.
    always_comb
    begin
        blen = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (code1_reg[i])
            begin
                blen = LW'(i + 1);
            end
        end
        if (fix1_reg)
        begin
            len_c = fl1_reg;
        end
        else if (blen == '0)
        begin
            len_c = '0;
        end
        else
        begin
            len_c = LW'({blen, 1'b0} - SHW'(1));
        end
    end

    always_comb
    begin
        v2_next    = v2_reg;
        op2_next   = op2_reg;
        code2_next = code2_reg;
        len2_next  = len2_reg;
        if (adv2)
        begin
            v2_next    = v1_reg;
            op2_next   = op1_reg;
            code2_next = code1_reg;
            len2_next  = len_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= op1_next;
        code1_reg <= code1_next;
        fix1_reg  <= fix1_next;
        fl1_reg   <= fl1_next;
        op2_reg   <= op2_next;
        code2_reg <= code2_next;
        len2_reg  <= len2_next;
    end

    // The leading zeros of an Exp-Golomb code come for free from left alignment.
    assign q_valid = v2_reg;
    assign q_op    = op2_reg;
    assign q_len   = len2_reg;
    assign q_s     = SW'(code2_reg) << (SHW'(SW) - SHW'(len2_reg));

endmodule

`default_nettype wire

// ===== rtl/core/egw_queue.sv =====
// Two-entry queue between the front end and the bit packer.
`default_nettype none

module egw_queue #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  egw_pkg::egw_op_t                     in_op,
    input  logic [2*VALUE_BITS-1:0]              in_s,
    input  logic [$clog2(2*VALUE_BITS)-1:0]      in_len,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output egw_pkg::egw_op_t                     out_op,
    output logic [2*VALUE_BITS-1:0]              out_s,
    output logic [$clog2(2*VALUE_BITS)-1:0]      out_len
);
    import egw_pkg::*;

    localparam int SW = 2 * VALUE_BITS;
    localparam int LW = $clog2(SW);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    egw_op_t       ent_op  [QUEUE_DEPTH];
    logic [SW-1:0] ent_s   [QUEUE_DEPTH];
    logic [LW-1:0] ent_len [QUEUE_DEPTH];

    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_op    = ent_op[rp_reg];
    assign out_s     = ent_s[rp_reg];
    assign out_len   = ent_len[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_op[wp_reg]  <= in_op;
            ent_s[wp_reg]   <= in_s;
            ent_len[wp_reg] <= in_len;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/egw_back.sv =====
// Bit packer: merges code words with the pending bits and emits bytes.
`default_nettype none

module egw_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  egw_pkg::egw_op_t                     q_op,
    input  logic [2*VALUE_BITS-1:0]              q_s,
    input  logic [$clog2(2*VALUE_BITS)-1:0]      q_len,
    egw_byte_if.source                           res
);
    import egw_pkg::*;

    localparam int SW = 2 * VALUE_BITS;
    localparam int LW = $clog2(SW);
    localparam int WW = SW + 8;
    localparam int NW = $clog2(WW);

    logic               busy_reg, busy_next;
    logic [WW-1:0]      win_reg, win_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [6:0]         pb_reg, pb_next;
    logic [2:0]         pc_reg, pc_next;
    egw_total_t         total_reg, total_next;
    logic               ov_reg, ov_next;
    egw_byte_t          ob_reg, ob_next;
    logic               olast_reg, olast_next;
    egw_total_t         otot_reg, otot_next;

    logic               slot_free;
    logic               load;
    logic               push;
    logic [SW-1:0]      s_eff;
    logic [LW-1:0]      len_eff;
    logic [WW-1:0]      win_load;
    logic [NW-1:0]      n_load;
    logic [WW-1:0]      win_shift;
    logic [NW-1:0]      n_shift;
    logic               is_last;
    logic [WW-1:0]      src_w;
    logic [2:0]         src_n;
    logic [6:0]         pb_new;
    logic [TOTAL_W:0]   total_sum;

    assign slot_free = !ov_reg || res.ready;
    assign q_ready   = !busy_reg;
    assign load      = q_valid && !busy_reg;
    assign push      = busy_reg && slot_free;

    always_comb
    begin
        if (q_op == OP_TRAIL)
        begin
            s_eff   = {1'b1, {(SW-1){1'b0}}};
            len_eff = LW'(4'd8 - {1'b0, pc_reg});
        end
        else
        begin
            s_eff   = q_s;
            len_eff = q_len;
        end
        // Pending bits go on top, the new code word right below them.
        win_load  = ({pb_reg, {(WW-7){1'b0}}} << (3'd7 - pc_reg))
                  | ({s_eff, 8'h00} >> pc_reg);
        n_load    = NW'(pc_reg) + NW'(len_eff);
        win_shift = win_reg << 8;
        n_shift   = n_reg - NW'(8);
        is_last   = (n_reg < NW'(16));
        src_w     = busy_reg ? win_shift : win_load;
        src_n     = busy_reg ? n_shift[2:0] : n_load[2:0];
        pb_new    = src_w[WW-1 -: 7] >> (3'd7 - src_n);
        total_sum = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(len_eff);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        win_next   = win_reg;
        n_next     = n_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        total_next = total_reg;
        ov_next    = ov_reg;
        ob_next    = ob_reg;
        olast_next = olast_reg;
        otot_next  = otot_reg;

        if (load)
        begin
            case (q_op)
                OP_RESTART:
                begin
                    pb_next    = '0;
                    pc_next    = '0;
                    total_next = '0;
                end
                OP_DATA, OP_TRAIL:
                begin
                    total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                    if (n_load >= NW'(8))
                    begin
                        busy_next = 1'b1;
                        win_next  = win_load;
                        n_next    = n_load;
                    end
                    else
                    begin
                        pb_next = pb_new;
                        pc_next = n_load[2:0];
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end

        if (push)
        begin
            ov_next    = 1'b1;
            ob_next    = win_reg[WW-1 -: 8];
            olast_next = is_last;
            otot_next  = total_reg;
            win_next   = win_shift;
            n_next     = n_shift;
            if (is_last)
            begin
                busy_next = 1'b0;
                pb_next   = pb_new;
                pc_next   = n_shift[2:0];
            end
        end
        else if (res.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pb_reg    <= '0;
            pc_reg    <= '0;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        n_reg     <= n_next;
        ob_reg    <= ob_next;
        olast_reg <= olast_next;
        otot_reg  <= otot_next;
    end

    assign res.valid      = ov_reg;
    assign res.out_byte   = ob_reg;
    assign res.last       = olast_reg;
    assign res.total_bits = otot_reg;

endmodule

`default_nettype wire

// ===== rtl/core/egw_checker.sv =====
// Port-level checks of the bit writer's byte channel, bound to the top level.
`default_nettype none

module egw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input egw_pkg::egw_byte_t  res_out_byte,
    input logic               res_last,
    input egw_pkg::egw_total_t res_total_bits
);
    import egw_pkg::*;

    // A byte the receiver has not taken stays as it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_byte)
            && $stable(res_last) && $stable(res_total_bits))
    else $error("stalled byte item changed");

    // Every emitted byte has been counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_total_bits >= 16'd8)
    else $error("bit count below one byte");

    // A byte that is not the last of its command means at least two bytes were written.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> res_total_bits >= 16'd16)
    else $error("bit count too small for a multi-byte command");

endmodule

bind exp_golomb_bit_writer_unit egw_checker u_egw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_out_byte   (res.out_byte),
    .res_last       (res.last),
    .res_total_bits (res.total_bits)
);

`default_nettype wire
